/* sv/ext2bm_pkg.sv */
// ext2bm_pkg: shared types, constants and reciprocal tables for the ext2 block map calculator.
// Used by ext2bm_front, ext2bm_cdiv and ext2_block_map_calc. No dependencies.
package ext2bm_pkg;

    typedef enum logic [1:0] {
        CMD_MAP     = 2'd0,
        CMD_COUNT   = 2'd1,
        CMD_CONTENT = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    // Range of a count/content operand against the indirect tiers
    typedef enum logic [1:0] {
        ZN_NONE   = 2'd0,
        ZN_SINGLE = 2'd1,
        ZN_DOUBLE = 2'd2,
        ZN_TRIPLE = 2'd3
    } t_zone;

    localparam logic [2:0] TIER_DIRECT = 3'd0;
    localparam logic [2:0] TIER_SINGLE = 3'd1;
    localparam logic [2:0] TIER_DOUBLE = 3'd2;
    localparam logic [2:0] TIER_TRIPLE = 3'd3;
    localparam logic [2:0] TIER_BEYOND = 3'd4;

    localparam logic [3:0] SLOT_SINGLE = 4'd12;
    localparam logic [3:0] SLOT_DOUBLE = 4'd13;
    localparam logic [3:0] SLOT_TRIPLE = 4'd14;

    localparam logic [3:0] SH_MIN    = 4'd8;
    localparam logic [3:0] SH_MAX    = 4'd10;
    localparam logic [3:0] SH_SECTOR = 4'd7;
    localparam logic [3:0] SH_RESET  = 4'd8;

    localparam int DIV_W   = 21;   // widest divisor p*p+p+1
    localparam int RECIP_W = 24;   // floor(2^32 / divisor)
    localparam int QUO_W   = 24;

    localparam logic [DIV_W-1:0] DIVP_8  = 21'd257;
    localparam logic [DIV_W-1:0] DIVP_9  = 21'd513;
    localparam logic [DIV_W-1:0] DIVP_10 = 21'd1025;
    localparam logic [DIV_W-1:0] DIVG_8  = 21'd65793;
    localparam logic [DIV_W-1:0] DIVG_9  = 21'd262657;
    localparam logic [DIV_W-1:0] DIVG_10 = 21'd1049601;

    localparam logic [RECIP_W-1:0] RECP_8  = 24'(33'h1_0000_0000 / 33'd257);
    localparam logic [RECIP_W-1:0] RECP_9  = 24'(33'h1_0000_0000 / 33'd513);
    localparam logic [RECIP_W-1:0] RECP_10 = 24'(33'h1_0000_0000 / 33'd1025);
    localparam logic [RECIP_W-1:0] RECG_8  = 24'(33'h1_0000_0000 / 33'd65793);
    localparam logic [RECIP_W-1:0] RECG_9  = 24'(33'h1_0000_0000 / 33'd262657);
    localparam logic [RECIP_W-1:0] RECG_10 = 24'(33'h1_0000_0000 / 33'd1049601);

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  sh;
        logic [2:0]  tier;
        logic [3:0]  slot;
        logic [9:0]  idx1;
        logic [9:0]  idx2;
        logic [9:0]  idx3;
        logic [31:0] n;
        t_zone       zone;
        logic [32:0] acc;
        logic [10:0] aux;
        logic [QUO_W-1:0] q1;
    } t_item;

    // Divisor p+1 (grp=0) or p*p+p+1 (grp=1) for a clamped shift
    function automatic logic [DIV_W-1:0] f_divisor(input logic [3:0] sh, input logic grp);
        logic [DIV_W-1:0] d;
        unique case (sh)
            4'd8:    d = grp ? DIVG_8 : DIVP_8;
            4'd9:    d = grp ? DIVG_9 : DIVP_9;
            default: d = grp ? DIVG_10 : DIVP_10;
        endcase
        return d;
    endfunction

    function automatic logic [RECIP_W-1:0] f_recip(input logic [3:0] sh, input logic grp);
        logic [RECIP_W-1:0] m;
        unique case (sh)
            4'd8:    m = grp ? RECG_8 : RECP_8;
            4'd9:    m = grp ? RECG_9 : RECP_9;
            default: m = grp ? RECG_10 : RECP_10;
        endcase
        return m;
    endfunction

endpackage

/* sv/ext2bm_cdiv.sv */
// ext2bm_cdiv: three-stage divider of a 32-bit value by a small constant divisor.
// Reciprocal multiply, back-multiply, one correction step. Uses ext2bm_pkg.
module ext2bm_cdiv (
    input  logic                           i_clk,
    input  logic [31:0]                    i_x,
    input  logic [ext2bm_pkg::DIV_W-1:0]   i_d,
    input  logic [ext2bm_pkg::RECIP_W-1:0] i_m,
    output logic [ext2bm_pkg::QUO_W-1:0]   o_q,
    output logic [ext2bm_pkg::DIV_W-1:0]   o_rem
);
    import ext2bm_pkg::*;

    localparam int PROD_W = 32 + RECIP_W;
    localparam int QD_W   = QUO_W + DIV_W;

    logic [PROD_W-1:0] r_a_prod;
    logic [31:0]       r_a_x;
    logic [DIV_W-1:0]  r_a_d;

    logic [QUO_W-1:0]  r_b_q;
    logic [31:0]       r_b_qd;
    logic [31:0]       r_b_x;
    logic [DIV_W-1:0]  r_b_d;

    logic [QUO_W-1:0]  n_b_q;
    logic [QD_W-1:0]   n_b_qd;
    logic [31:0]       diff_full;
    logic [DIV_W:0]    diff;
    logic [QUO_W-1:0]  n_q;
    logic [DIV_W-1:0]  n_rem;

    // Estimate is the true quotient or one below it
    always_comb begin
        n_b_q     = r_a_prod[PROD_W-1:32];
        n_b_qd    = {{DIV_W{1'b0}}, n_b_q} * {{QUO_W{1'b0}}, r_a_d};
        diff_full = r_b_x - r_b_qd;
        diff      = diff_full[DIV_W:0];
        if (diff >= {1'b0, r_b_d}) begin
            n_q   = r_b_q + QUO_W'(1);
            n_rem = DIV_W'(diff - {1'b0, r_b_d});
        end else begin
            n_q   = r_b_q;
            n_rem = diff[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_prod <= {{RECIP_W{1'b0}}, i_x} * {{32{1'b0}}, i_m};
        r_a_x    <= i_x;
        r_a_d    <= i_d;
        r_b_q    <= n_b_q;
        r_b_qd   <= n_b_qd[31:0];
        r_b_x    <= r_a_x;
        r_b_d    <= r_a_d;
        o_q      <= n_q;
        o_rem    <= n_rem;
    end

endmodule

/* sv/ext2bm_front.sv */
// ext2bm_front: first pipeline stage; clamps the shift, resolves map paths and
// classifies count/content operands into tiers. Uses ext2bm_pkg.
module ext2bm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [1:0]            i_command,
    input  logic [31:0]           i_operand,
    input  logic [3:0]            i_ptr_shift,
    output logic                  o_valid,
    output ext2bm_pkg::t_item     o_item
);
    import ext2bm_pkg::*;

    logic [3:0]  sh;
    logic [4:0]  sh2;
    logic [32:0] p33;
    logic [32:0] pp33;
    logic [32:0] ppp33;
    logic [32:0] m33;
    logic [32:0] off;
    logic [32:0] b1;
    logic [32:0] b2;
    logic [32:0] b3;
    logic [32:0] rm;
    logic [31:0] nc;
    logic [32:0] nc33;
    logic [31:0] p32;
    logic [31:0] pp32;
    t_item       n_item;

    always_comb begin
        priority if (i_ptr_shift < SH_MIN) begin
            sh = SH_MIN;
        end else if (i_ptr_shift > SH_MAX) begin
            sh = SH_MAX;
        end else begin
            sh = i_ptr_shift;
        end
        sh2   = {sh, 1'b0};
        p33   = 33'd1 << sh;
        pp33  = 33'd1 << sh2;
        ppp33 = 33'd1 << (sh2 + 5'(sh));
        m33   = p33 - 33'd1;
        off   = {1'b0, i_operand};
        b1    = 33'd12 + p33;
        b2    = b1 + pp33;
        b3    = b2 + ppp33;
        nc    = i_operand >> (sh - SH_SECTOR);
        nc33  = {1'b0, nc};
        p32   = p33[31:0];
        pp32  = pp33[31:0];
        rm    = '0;

        n_item      = '0;
        n_item.cmd  = t_cmd'(i_command);
        n_item.sh   = sh;
        n_item.zone = ZN_NONE;

        // Map path
        priority if (off < 33'd12) begin
            n_item.tier = TIER_DIRECT;
            n_item.slot = i_operand[3:0];
        end else if (off < b1) begin
            n_item.tier = TIER_SINGLE;
            n_item.slot = SLOT_SINGLE;
            n_item.idx1 = 10'(off - 33'd12);
        end else if (off < b2) begin
            rm          = off - b1;
            n_item.tier = TIER_DOUBLE;
            n_item.slot = SLOT_DOUBLE;
            n_item.idx1 = 10'((rm >> sh) & m33);
            n_item.idx2 = 10'(rm & m33);
        end else if (off < b3) begin
            rm          = off - b2;
            n_item.tier = TIER_TRIPLE;
            n_item.slot = SLOT_TRIPLE;
            n_item.idx1 = 10'((rm >> sh2) & m33);
            n_item.idx2 = 10'((rm >> sh) & m33);
            n_item.idx3 = 10'(rm & m33);
        end else begin
            n_item.tier = TIER_BEYOND;
        end

        if (n_item.cmd == CMD_CONTENT) begin
            n_item.n = nc;
            priority if (nc33 <= 33'd12) begin
                n_item.zone = ZN_NONE;
            end else if (nc33 <= 33'd13 + p33) begin
                n_item.zone = ZN_SINGLE;
            end else if (nc33 <= 33'd14 + p33 + p33 + pp33) begin
                n_item.zone = ZN_DOUBLE;
                n_item.acc  = {1'b0, nc - 32'd15 - p32};
            end else begin
                n_item.zone = ZN_TRIPLE;
                n_item.acc  = {1'b0, nc - 32'd16 - p32 - p32 - pp32};
            end
        end else begin
            n_item.n = i_operand;
            priority if (off <= 33'd12) begin
                n_item.zone = ZN_NONE;
            end else if (off <= b1) begin
                n_item.zone = ZN_SINGLE;
            end else if (off <= b2) begin
                n_item.zone = ZN_DOUBLE;
                n_item.acc  = off - b1;
            end else begin
                n_item.zone = ZN_TRIPLE;
                n_item.acc  = off - b2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_item <= n_item;
    end

endmodule

/* sv/ext2_block_map_calc.sv */
// ext2_block_map_calc: pipelined ext2 block map index, sector count and content count.
// o_done pulses once for each i_start taken, for all commands, through the 8-stage pipeline
// (front stage, two chained 3-stage constant dividers, output register).
// Throughput: one transaction per clock; o_busy is always low.
// Reset (synchronous, active low) clears the valid chain and sets ptr_shift to 8.
// Depends on ext2bm_pkg, ext2bm_front, ext2bm_cdiv.
module ext2_block_map_calc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_operand,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output logic        o_done,
    output logic [2:0]  o_tier,
    output logic [3:0]  o_top_slot,
    output logic [9:0]  o_index_first,
    output logic [9:0]  o_index_second,
    output logic [9:0]  o_index_third,
    output logic [31:0] o_value,
    output logic        o_overflow
);
    import ext2bm_pkg::*;

    logic [3:0]  r_ptr_shift;

    logic        s1_vld;
    t_item       s1_item;
    logic [7:2]  r_vld;
    t_item       r_s2;
    t_item       r_s3;
    t_item       r_s4;
    t_item       r_s5;
    t_item       r_s6;
    t_item       r_s7;
    t_item       n_s2;
    t_item       n_s3;
    t_item       n_s4;
    t_item       n_s5;

    logic [QUO_W-1:0] d1_q;
    logic [DIV_W-1:0] d1_rem;
    logic [QUO_W-1:0] d2_q;
    logic [DIV_W-1:0] d2_rem;
    logic [31:0]      d2_x;

    logic [32:0] p2;
    logic [32:0] pp2;
    logic [32:0] last2;
    logic [32:0] p3;
    logic [35:0] total;
    logic [31:0] p32;
    logic [31:0] q1x;
    logic [31:0] extra;

    logic [2:0]  n_tier;
    logic [3:0]  n_slot;
    logic [9:0]  n_idx1;
    logic [9:0]  n_idx2;
    logic [9:0]  n_idx3;
    logic [31:0] n_value;
    logic        n_ovf;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_shift <= SH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ptr_shift <= i_cfg_data;
        end
    end

    ext2bm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_start && !o_busy),
        .i_command   (i_command),
        .i_operand   (i_operand),
        .i_ptr_shift (r_ptr_shift),
        .o_valid     (s1_vld),
        .o_item      (s1_item)
    );

    // First division: by p+1 in the double range, by p*p+p+1 beyond it
    ext2bm_cdiv u_div1 (
        .i_clk (i_clk),
        .i_x   (s1_item.acc[31:0]),
        .i_d   (f_divisor(s1_item.sh, s1_item.zone == ZN_TRIPLE)),
        .i_m   (f_recip(s1_item.sh, s1_item.zone == ZN_TRIPLE)),
        .o_q   (d1_q),
        .o_rem (d1_rem)
    );

    // Remainder minus one wraps when the remainder is zero
    assign d2_x = {{(32-DIV_W){1'b0}}, d1_rem} - 32'd1;

    ext2bm_cdiv u_div2 (
        .i_clk (i_clk),
        .i_x   (d2_x),
        .i_d   (f_divisor(r_s4.sh, 1'b0)),
        .i_m   (f_recip(r_s4.sh, 1'b0)),
        .o_q   (d2_q),
        .o_rem (d2_rem)
    );

    // Sector count: ceiling terms, then indirect total, then add content blocks
    always_comb begin
        p2    = 33'd1 << s1_item.sh;
        pp2   = 33'd1 << {s1_item.sh, 1'b0};
        last2 = ((s1_item.acc - 33'd1) & (pp2 - 33'd1)) + 33'd1;
        n_s2  = s1_item;
        if (s1_item.cmd == CMD_COUNT) begin
            n_s2.aux = '0;
            unique case (s1_item.zone)
                ZN_NONE:   n_s2.acc = 33'd0;
                ZN_SINGLE: n_s2.acc = 33'd1;
                ZN_DOUBLE: n_s2.acc = 33'd2 + ((s1_item.acc + p2 - 33'd1) >> s1_item.sh);
                default: begin
                    n_s2.acc = (s1_item.acc + pp2 - 33'd1) >> {s1_item.sh, 1'b0};
                    n_s2.aux = 11'((last2 + p2 - 33'd1) >> s1_item.sh);
                end
            endcase
        end

        p3   = 33'd1 << r_s2.sh;
        n_s3 = r_s2;
        if (r_s2.cmd == CMD_COUNT && r_s2.zone == ZN_TRIPLE) begin
            n_s3.acc = 33'd3 + p3 + r_s2.acc + ((r_s2.acc - 33'd1) << r_s2.sh)
                     + {22'd0, r_s2.aux};
        end

        n_s4 = r_s3;
        if (r_s3.cmd == CMD_COUNT) begin
            n_s4.acc = {1'b0, r_s3.n} + r_s3.acc;
        end

        n_s5    = r_s4;
        n_s5.q1 = d1_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:2], s1_vld};
        end
        r_s2 <= n_s2;
        r_s3 <= n_s3;
        r_s4 <= n_s4;
        r_s5 <= n_s5;
        r_s6 <= r_s5;
        r_s7 <= r_s6;
    end

    // Output stage: select per command, zero everything the command does not produce
    always_comb begin
        total = {3'd0, r_s7.acc} << (r_s7.sh - SH_SECTOR);
        p32   = 32'd1 << r_s7.sh;
        q1x   = {{(32-QUO_W){1'b0}}, r_s7.q1};
        unique case (r_s7.zone)
            ZN_NONE:   extra = 32'd0;
            ZN_SINGLE: extra = 32'd1;
            ZN_DOUBLE: extra = 32'd3 + q1x;
            default:   extra = p32 + 32'd5 + (q1x << r_s7.sh) + q1x
                             + {{(32-QUO_W){1'b0}}, d2_q};
        endcase
        n_tier  = '0;
        n_slot  = '0;
        n_idx1  = '0;
        n_idx2  = '0;
        n_idx3  = '0;
        n_value = '0;
        n_ovf   = 1'b0;
        unique case (r_s7.cmd)
            CMD_MAP: begin
                n_tier = r_s7.tier;
                n_slot = r_s7.slot;
                n_idx1 = r_s7.idx1;
                n_idx2 = r_s7.idx2;
                n_idx3 = r_s7.idx3;
            end
            CMD_COUNT: begin
                if (|total[35:32]) begin
                    n_value = 32'hFFFF_FFFF;
                    n_ovf   = 1'b1;
                end else begin
                    n_value = total[31:0];
                end
            end
            CMD_CONTENT: begin
                n_value = r_s7.n - extra;
            end
            default: begin
                n_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_vld[7];
        end
        o_tier         <= n_tier;
        o_top_slot     <= n_slot;
        o_index_first  <= n_idx1;
        o_index_second <= n_idx2;
        o_index_third  <= n_idx3;
        o_value        <= n_value;
        o_overflow     <= n_ovf;
    end

endmodule

/* sim/tb_ext2_block_map_calc.sv */
// Testbench for ext2_block_map_calc: directed and random map, count, content and nop commands.
// Expected results are computed by an in-bench predictor; depends on ext2bm_pkg and the RTL.
module tb_ext2_block_map_calc;
    timeunit 1ns;
    timeprecision 1ps;
    import ext2bm_pkg::*;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] opd;
    } t_req;

    typedef struct {
        logic [2:0]  tier;
        logic [3:0]  slot;
        logic [9:0]  idx1;
        logic [9:0]  idx2;
        logic [9:0]  idx3;
        logic [31:0] value;
        logic        ovf;
    } t_res;

    localparam int DRAIN_CYCLES = 20;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_command;
    logic [31:0] i_operand;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        o_done;
    logic [2:0]  o_tier;
    logic [3:0]  o_top_slot;
    logic [9:0]  o_index_first;
    logic [9:0]  o_index_second;
    logic [9:0]  o_index_third;
    logic [31:0] o_value;
    logic        o_overflow;

    ext2_block_map_calc uut (.*);

    t_req   pending_q[$];
    t_res   expected_q[$];
    logic [3:0] shift_reg;
    int     idle_pct;
    int     error_count;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = 1'b1;
            #5 i_clk = 1'b0;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    function automatic t_res compute_block_map(input t_cmd cmd, input logic [31:0] opd,
                                               input logic [3:0] reg_sh);
        t_res r;
        int unsigned sh;
        longint unsigned p, m, pp, ppp, off, rem, extra, total, nd, last, n64;
        logic [31:0] n, p32, pp32, ex, grp, rr;
        r = '{default: '0};
        sh = (reg_sh < 8) ? 8 : (reg_sh > 10) ? 10 : reg_sh;
        p = 64'd1 << sh;
        m = p - 1;
        pp = p * p;
        ppp = pp * p;
        case (cmd)
            CMD_MAP: begin
                off = opd;
                if (off < 12) begin
                    r.tier = TIER_DIRECT; r.slot = off[3:0];
                end else if (off < 12 + p) begin
                    r.tier = TIER_SINGLE; r.slot = SLOT_SINGLE; r.idx1 = 10'(off - 12);
                end else if (off < 12 + p + pp) begin
                    rem = off - 12 - p;
                    r.tier = TIER_DOUBLE; r.slot = SLOT_DOUBLE;
                    r.idx1 = 10'((rem >> sh) & m); r.idx2 = 10'(rem & m);
                end else if (off < 12 + p + pp + ppp) begin
                    rem = off - 12 - p - pp;
                    r.tier = TIER_TRIPLE; r.slot = SLOT_TRIPLE;
                    r.idx1 = 10'((rem >> (2 * sh)) & m);
                    r.idx2 = 10'((rem >> sh) & m);
                    r.idx3 = 10'(rem & m);
                end else begin
                    r.tier = TIER_BEYOND;
                end
            end
            CMD_COUNT: begin
                n64 = opd;
                if (n64 <= 12) extra = 0;
                else if (n64 <= 12 + p) extra = 1;
                else if (n64 <= 12 + p + pp) begin
                    rem = n64 - 12 - p;
                    extra = 2 + (rem + p - 1) / p;
                end else begin
                    rem = n64 - 12 - p - pp;
                    nd = (rem + pp - 1) / pp;
                    last = 1 + (rem - 1) % pp;
                    extra = 3 + p + nd + (nd - 1) * p + (last + p - 1) / p;
                end
                total = (n64 + extra) << (sh - 7);
                if (total > 64'hFFFF_FFFF) begin
                    r.value = 32'hFFFF_FFFF; r.ovf = 1'b1;
                end else begin
                    r.value = total[31:0];
                end
            end
            CMD_CONTENT: begin
                n = opd >> (sh - 7);
                p32 = 32'd1 << sh;
                pp32 = p32 * p32;
                if (n <= 12) ex = 0;
                else if (n <= 12 + p32 + 1) ex = 1;
                else if (n <= 12 + p32 + pp32 + 2 + p32) begin
                    rr = n - 12 - p32 - 3;
                    ex = 3 + rr / (p32 + 1);
                end else begin
                    grp = pp32 + p32 + 1;
                    rr = n - 12 - p32 - pp32 - 4 - p32;
                    ex = 5 + p32;
                    ex += (p32 + 1) * (rr / grp);
                    rr = rr % grp;
                    rr = rr - 1;
                    ex += rr / (p32 + 1);
                end
                r.value = n - ex;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Pick operands near the tier edges for the current shift, or small, near-maximum or fully random values
    function automatic logic [31:0] pick_operand(input logic [3:0] reg_sh);
        longint unsigned p, b;
        int unsigned sh;
        sh = (reg_sh < 8) ? 8 : (reg_sh > 10) ? 10 : reg_sh;
        p = 64'd1 << sh;
        case ($urandom_range(0, 9))
            0: b = 12;
            1: b = 12 + p;
            2: b = 12 + p + p * p;
            3: b = 12 + p + p * p + p * p * p;
            4: b = (12 + p + p * p + 3 + p) << (sh - 7);
            5: return 32'($urandom_range(0, 40));
            6: return 32'hFFFF_FFFF - $urandom_range(0, 5);
            default: return $urandom;
        endcase
        b = b + $urandom_range(0, 6) - 3;
        return b[31:0];
    endfunction

    // Driver: present queued commands, gap at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            i_start   <= 1'b1;
            i_command <= pending_q[0].cmd;
            i_operand <= pending_q[0].opd;
            expected_q.push_back(compute_block_map(pending_q[0].cmd, pending_q[0].opd,
                                                   shift_reg));
            void'(pending_q.pop_front());
        end else begin
            i_start <= 1'b0;
        end
    end

    // Monitor: check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", o_value, 0);
            end else begin
                e = expected_q.pop_front();
                if (o_tier !== e.tier) report("tier", o_tier, e.tier);
                if (o_top_slot !== e.slot) report("top_slot", o_top_slot, e.slot);
                if (o_index_first !== e.idx1) report("index_first", o_index_first, e.idx1);
                if (o_index_second !== e.idx2) report("index_second", o_index_second, e.idx2);
                if (o_index_third !== e.idx3) report("index_third", o_index_third, e.idx3);
                if (o_value !== e.value) report("value", o_value, e.value);
                if (o_overflow !== e.ovf) report("overflow", o_overflow, e.ovf);
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_ext2_block_map_calc: done, errors");
            $finish;
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_shift(input logic [3:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shift_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_directed();
        t_req q;
        logic [31:0] edges[$];
        edges = '{32'd0, 32'd11, 32'd12, 32'd13, 32'hFFFF_FFFF, 32'h8000_0000};
        foreach (edges[k]) begin
            for (int c = 0; c < 4; c++) begin
                q.cmd = t_cmd'(c);
                q.opd = edges[k];
                pending_q.push_back(q);
            end
        end
    endtask

    initial begin
        t_req q;
        logic [3:0] shifts[$];
        shifts = '{4'd8, 4'd10, 4'd9, 4'd0, 4'd15, 4'd7, 4'd11, 4'd8};
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_command = '0;
        i_operand = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        shift_reg = SH_RESET;
        idle_pct = 28;
        error_count = 0;
        cycle_count = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        queue_directed();
        drain();
        foreach (shifts[s]) begin
            write_shift(shifts[s]);
            if (s == 0) queue_directed();
            for (int i = 0; i < 160; i++) begin
                q.cmd = t_cmd'($urandom_range(0, 12) == 0 ? 3 : $urandom_range(0, 2));
                q.opd = pick_operand(shift_reg);
                pending_q.push_back(q);
            end
            idle_pct = (s < 3) ? 28 : (s < 6) ? 83 : 0;
            drain();
        end
        if (error_count == 0) begin
            $display("tb_ext2_block_map_calc: done, clean");
        end else begin
            $display("tb_ext2_block_map_calc: done, errors");
        end
        $finish;
    end
endmodule

/* sim.f */
sv/ext2bm_pkg.sv
sv/ext2bm_cdiv.sv
sv/ext2bm_front.sv
sv/ext2_block_map_calc.sv
sim/tb_ext2_block_map_calc.sv
